// ===== hdl/wcu8_pkg.sv =====
package wcu8_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int JOB_BYTES   = 7;

    localparam logic [15:0] SURR_MASK   = 16'hFC00;
    localparam logic [15:0] SURR_HIGH   = 16'hD800;
    localparam logic [15:0] SURR_LOW    = 16'hDC00;
    localparam logic [31:0] PLANE1_BASE = 32'h0001_0000;
    localparam logic [31:0] CODE_MAX    = 32'h0010_FFFF;
    localparam logic [7:0]  LEAD2       = 8'hC0;
    localparam logic [7:0]  LEAD3       = 8'hE0;
    localparam logic [7:0]  LEAD4       = 8'hF0;
    localparam logic [7:0]  CONT        = 8'h80;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      len;
    } t_seg;

    typedef struct packed {
        logic [JOB_BYTES-1:0][7:0] bytes;
        logic [2:0]                cnt;
        logic                      term;
    } t_job;

    function automatic t_seg enc_three(input logic [31:0] v);
        t_seg s;
        s          = '0;
        s.bytes[0] = LEAD3 | v[19:12];
        s.bytes[1] = CONT | {2'b00, v[11:6]};
        s.bytes[2] = CONT | {2'b00, v[5:0]};
        s.len      = 3'd3;
        return s;
    endfunction

    function automatic t_seg enc_four(input logic [31:0] v);
        t_seg s;
        s          = '0;
        s.bytes[0] = LEAD4 | {5'b00000, v[20:18]};
        s.bytes[1] = CONT | {2'b00, v[17:12]};
        s.bytes[2] = CONT | {2'b00, v[11:6]};
        s.bytes[3] = CONT | {2'b00, v[5:0]};
        s.len      = 3'd4;
        return s;
    endfunction

    function automatic t_seg enc_short(input logic [31:0] v);
        t_seg s;
        s = '0;
        if (v < 32'h80) begin
            s.bytes[0] = v[7:0];
            s.len      = 3'd1;
        end else if (v < 32'h800) begin
            s.bytes[0] = LEAD2 | {3'b000, v[10:6]};
            s.bytes[1] = CONT | {2'b00, v[5:0]};
            s.len      = 3'd2;
        end else begin
            s = enc_three(v);
        end
        return s;
    endfunction

    function automatic t_job pack_job(input t_seg p1, input t_seg p2, input logic term);
        t_job       j;
        logic [3:0] k;
        logic [3:0] l1;
        logic [3:0] l12;
        logic [3:0] d;
        j   = '0;
        l1  = {1'b0, p1.len};
        l12 = l1 + {1'b0, p2.len};
        for (int i = 0; i < JOB_BYTES; i++) begin
            k = 4'(i);
            d = k - l1;
            if (k < l1) begin
                j.bytes[i] = p1.bytes[k[1:0]];
            end else if (k < l12) begin
                j.bytes[i] = p2.bytes[d[1:0]];
            end else begin
                j.bytes[i] = 8'h00;
            end
        end
        j.cnt  = 3'(l12 + {3'b000, term});
        j.term = term;
        return j;
    endfunction

endpackage

// ===== hdl/wide_char_to_utf8_encoder.sv =====
// An item's bytes go through the job queue and then the output job register before output.
// One byte per cycle while i_stall is low and the queue holds jobs; an item causing no
// byte pushes no job. The single byte lane sets this rate.
// A short job queue lets input keep flowing while earlier bytes wait to be taken.
// Synchronous active-low reset clears the mode, held surrogate, discard flag, queue and output.
module wide_char_to_utf8_encoder #(
    parameter int P_QUEUE_DEPTH = wcu8_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_code_unit,
    input  logic        i_ends_text,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_utf8_byte,
    output logic        o_last_of_run,
    output logic        o_is_terminator
);
    import wcu8_pkg::*;

    logic push;
    logic full;
    logic q_valid;
    logic pop;
    t_job f_job;
    t_job q_job;

    wcu8_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_code_unit (i_code_unit),
        .i_ends_text (i_ends_text),
        .o_push      (push),
        .o_job       (f_job),
        .i_full      (full)
    );

    wcu8_queue #(
        .DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (f_job),
        .o_full  (full),
        .o_valid (q_valid),
        .o_job   (q_job),
        .i_pop   (pop)
    );

    wcu8_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_q_job         (q_job),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_utf8_byte     (o_utf8_byte),
        .o_last_of_run   (o_last_of_run),
        .o_is_terminator (o_is_terminator)
    );

endmodule

// ===== hdl/wcu8_front.sv =====
module wcu8_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [31:0]   i_code_unit,
    input  logic          i_ends_text,
    output logic          o_push,
    output wcu8_pkg::t_job o_job,
    input  logic          i_full
);
    import wcu8_pkg::*;

    logic        r_mode;
    logic [15:0] r_held;
    logic        r_pend;
    logic        r_disc;
    logic [15:0] n_held;
    logic        n_pend;
    logic        n_disc;

    t_seg        seg1;
    t_seg        seg2;
    logic        term;
    logic        done;
    logic        consumed;
    logic [15:0] u;
    logic [20:0] pair;
    logic        accept;
    t_job        job;

    assign u    = i_code_unit[15:0];
    assign pair = {1'b0, r_held[9:0], u[9:0]} + PLANE1_BASE[20:0];

    always_comb begin
        seg1     = '0;
        seg2     = '0;
        term     = 1'b0;
        done     = 1'b0;
        consumed = 1'b0;
        n_held   = r_held;
        n_pend   = r_pend;
        n_disc   = r_disc;
        if (r_disc) begin
            if (i_ends_text) begin
                n_disc = 1'b0;
            end
        end else begin
            if (r_mode) begin
                n_pend = 1'b0;
                n_held = '0;
                if (i_code_unit == '0) begin
                    done = 1'b1;
                end else if (i_code_unit < PLANE1_BASE || i_code_unit > CODE_MAX) begin
                    seg1 = enc_short(i_code_unit);
                end else begin
                    seg1 = enc_four(i_code_unit);
                end
            end else begin
                if (r_pend) begin
                    n_pend = 1'b0;
                    n_held = '0;
                    if ((u & SURR_MASK) == SURR_LOW) begin
                        seg1     = enc_four({11'b0, pair});
                        consumed = 1'b1;
                    end else begin
                        seg1 = enc_three({16'b0, r_held});
                    end
                end
                if (!consumed) begin
                    if (u == '0) begin
                        done = 1'b1;
                    end else if ((u & SURR_MASK) == SURR_HIGH && !i_ends_text) begin
                        n_held = u;
                        n_pend = 1'b1;
                    end else begin
                        seg2 = enc_short({16'b0, u});
                    end
                end
            end
            if (done || i_ends_text) begin
                term = 1'b1;
                if (done && !i_ends_text) begin
                    n_disc = 1'b1;
                end
            end
        end
    end

    assign job     = pack_job(seg1, seg2, term);
    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept && (job.cnt != 3'd0);
    assign o_job   = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_held <= '0;
            r_pend <= 1'b0;
            r_disc <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (accept) begin
                r_held <= n_held;
                r_pend <= n_pend;
                r_disc <= n_disc;
            end
        end
    end

endmodule

// ===== hdl/wcu8_queue.sv =====
module wcu8_queue #(
    parameter int DEPTH = wcu8_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  wcu8_pkg::t_job i_job,
    output logic           o_full,
    output logic           o_valid,
    output wcu8_pkg::t_job o_job,
    input  logic           i_pop
);
    import wcu8_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/wcu8_back.sv =====
module wcu8_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  wcu8_pkg::t_job i_q_job,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_stall,
    output logic [7:0]     o_utf8_byte,
    output logic           o_last_of_run,
    output logic           o_is_terminator
);
    import wcu8_pkg::*;

    t_job       r_job;
    logic [2:0] r_idx;
    logic       r_busy;
    logic       last;
    logic       take;

    assign last            = (r_idx == r_job.cnt - 3'd1);
    assign take            = r_busy && !i_stall;
    assign o_pop           = i_q_valid && (!r_busy || (take && last));
    assign o_valid         = r_busy;
    assign o_utf8_byte     = r_job.bytes[r_idx];
    assign o_last_of_run   = last;
    assign o_is_terminator = last && r_job.term;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_q_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_busy <= 1'b0;
        end else begin
            if (o_pop) begin
                r_idx  <= '0;
                r_busy <= 1'b1;
            end else if (take && last) begin
                r_busy <= 1'b0;
            end else if (take) begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;

    import wcu8_pkg::*;

    typedef struct {
        logic [31:0] code;
        logic        fin;
    } t_wide_unit;

    typedef struct {
        logic [7:0] b;
        logic       last_flag;
        logic       term;
    } t_utf8_out;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_wdata;
    logic        i_valid;
    logic        o_stall;
    logic [31:0] i_code_unit;
    logic        i_ends_text;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_utf8_byte;
    logic        o_last_of_run;
    logic        o_is_terminator;

    t_wide_unit  units_to_send[$];
    t_utf8_out   pending_bytes[$];
    t_utf8_out   run_bytes[$];

    logic        mode_32;
    logic [15:0] held_high;
    logic        surr_held;
    logic        discarding;

    logic        req_accepted;
    int          queued_total;
    int          units_taken;
    int          byte_errors;
    int          burst_left;
    int          gap_left;
    int          stall_cyc;
    int          stall_mode;
    int          hold_left;
    logic        hold_done;

    wide_char_to_utf8_encoder DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_code_unit     (i_code_unit),
        .i_ends_text     (i_ends_text),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_utf8_byte     (o_utf8_byte),
        .o_last_of_run   (o_last_of_run),
        .o_is_terminator (o_is_terminator)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void add_byte(logic [7:0] b, logic term);
        t_utf8_out r;
        r.b         = b;
        r.last_flag = 1'b0;
        r.term      = term;
        run_bytes.push_back(r);
    endfunction

    function automatic void add_three(logic [31:0] v);
        add_byte(LEAD3 | v[19:12], 1'b0);
        add_byte(CONT | {2'b00, v[11:6]}, 1'b0);
        add_byte(CONT | {2'b00, v[5:0]}, 1'b0);
    endfunction

    function automatic void add_four(logic [31:0] v);
        add_byte(LEAD4 | {5'b00000, v[20:18]}, 1'b0);
        add_byte(CONT | {2'b00, v[17:12]}, 1'b0);
        add_byte(CONT | {2'b00, v[11:6]}, 1'b0);
        add_byte(CONT | {2'b00, v[5:0]}, 1'b0);
    endfunction

    function automatic void add_short(logic [31:0] v);
        if (v < 32'h80) begin
            add_byte(v[7:0], 1'b0);
        end else if (v < 32'h800) begin
            add_byte(LEAD2 | {3'b000, v[10:6]}, 1'b0);
            add_byte(CONT | {2'b00, v[5:0]}, 1'b0);
        end else begin
            add_three(v);
        end
    endfunction

    function automatic void encode_unit(logic [31:0] cu, logic fin);
        logic [15:0] u;
        logic [31:0] v;
        logic        ended;
        logic        paired;
        run_bytes.delete();
        ended  = 1'b0;
        paired = 1'b0;
        if (discarding) begin
            if (fin) begin
                discarding = 1'b0;
            end
            return;
        end
        if (mode_32) begin
            surr_held = 1'b0;
            held_high = 16'h0000;
            if (cu == 32'h0) begin
                ended = 1'b1;
            end else if (cu < PLANE1_BASE || cu > CODE_MAX) begin
                add_short(cu);
            end else begin
                add_four(cu);
            end
        end else begin
            u = cu[15:0];
            if (surr_held) begin
                surr_held = 1'b0;
                if ((u & SURR_MASK) == SURR_LOW) begin
                    v = {12'h000, held_high[9:0], u[9:0]} + PLANE1_BASE;
                    add_four(v);
                    paired = 1'b1;
                end else begin
                    add_three({16'h0000, held_high});
                end
                held_high = 16'h0000;
            end
            if (!paired) begin
                if (u == 16'h0000) begin
                    ended = 1'b1;
                end else if ((u & SURR_MASK) == SURR_HIGH && !fin) begin
                    held_high = u;
                    surr_held = 1'b1;
                end else begin
                    add_short({16'h0000, u});
                end
            end
        end
        if (ended || fin) begin
            add_byte(8'h00, 1'b1);
            if (ended && !fin) begin
                discarding = 1'b1;
            end
        end
        if (run_bytes.size() > 0) begin
            run_bytes[run_bytes.size() - 1].last_flag = 1'b1;
        end
        foreach (run_bytes[k]) begin
            pending_bytes.push_back(run_bytes[k]);
        end
    endfunction

    function automatic void report_mismatch(string what);
        byte_errors++;
        if (byte_errors <= 10) begin
            $display("MISMATCH: %s", what);
        end
    endfunction

    always @(posedge i_clk) begin : check_and_predict
        t_utf8_out want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (pending_bytes.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte %h last %b term %b",
                        o_utf8_byte, o_last_of_run, o_is_terminator));
                end else begin
                    want = pending_bytes.pop_front();
                    if (o_utf8_byte !== want.b || o_last_of_run !== want.last_flag
                            || o_is_terminator !== want.term) begin
                        report_mismatch($sformatf(
                            "byte exp %h/%b/%b got %h/%b/%b",
                            want.b, want.last_flag, want.term,
                            o_utf8_byte, o_last_of_run, o_is_terminator));
                    end
                end
            end
            if (i_valid && !o_stall) begin
                encode_unit(i_code_unit, i_ends_text);
                units_taken++;
            end
        end
        req_accepted <= i_rst_n && i_valid && !o_stall;
    end

    always @(negedge i_clk) begin : drive_requests
        t_wide_unit nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || req_accepted) begin
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (units_to_send.size() > 0) begin
                nxt = units_to_send.pop_front();
                i_valid     <= 1'b1;
                i_code_unit <= nxt.code;
                i_ends_text <= nxt.fin;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 12);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        stall_cyc++;
        if (!hold_done && units_taken >= 50) begin
            hold_done = 1'b1;
            hold_left = 80;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            if (stall_cyc % 50 == 0) begin
                stall_mode = $urandom_range(0, 3);
            end
            case (stall_mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 3) == 0);
                2: i_stall <= ($urandom_range(0, 9) < 7);
                default: i_stall <= (stall_cyc % 3 == 0);
            endcase
        end
    end

    task automatic add_unit(logic [31:0] cu, logic fin);
        t_wide_unit w;
        w.code = cu;
        w.fin  = fin;
        units_to_send.push_back(w);
        queued_total++;
    endtask

    task automatic queue_text16(int len);
        int          k;
        int          sel;
        logic [15:0] upper;
        logic [15:0] cu16;
        k = 0;
        while (k < len) begin
            sel   = $urandom_range(0, 99);
            upper = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'h0000;
            if (sel < 20 && k + 1 < len) begin
                add_unit({upper, 6'b110110, 10'($urandom)}, 1'b0);
                add_unit({16'h0000, 6'b110111, 10'($urandom)}, k + 2 == len);
                k += 2;
            end else begin
                if (sel < 40) begin
                    cu16 = 16'($urandom_range(1, 16'h7F));
                end else if (sel < 55) begin
                    cu16 = 16'($urandom_range(16'h80, 16'h7FF));
                end else if (sel < 75) begin
                    cu16 = ($urandom_range(0, 1) == 0) ?
                        16'($urandom_range(16'h800, 16'hD7FF)) :
                        16'($urandom_range(16'hE000, 16'hFFFF));
                end else if (sel < 83) begin
                    cu16 = {6'b110110, 10'($urandom)};
                end else if (sel < 90) begin
                    cu16 = {6'b110111, 10'($urandom)};
                end else if (sel < 93) begin
                    cu16 = 16'h0000;
                end else begin
                    cu16 = 16'($urandom);
                end
                add_unit({upper, cu16}, k + 1 == len);
                k++;
            end
        end
    endtask

    task automatic queue_text32(int len);
        int          sel;
        logic [31:0] cu;
        for (int k = 0; k < len; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 18) begin
                cu = $urandom_range(1, 32'h7F);
            end else if (sel < 33) begin
                cu = $urandom_range(32'h80, 32'h7FF);
            end else if (sel < 50) begin
                cu = $urandom_range(32'h800, 32'hFFFF);
            end else if (sel < 72) begin
                cu = $urandom_range(32'h10000, 32'h10FFFF);
            end else if (sel < 85) begin
                cu = $urandom_range(32'h110000, 32'hFFFFFFFF);
            end else if (sel < 88) begin
                cu = 32'h0;
            end else begin
                cu = $urandom;
            end
            add_unit(cu, k == len - 1);
        end
    endtask

    task automatic queue_noise(int len);
        logic [31:0] cu;
        for (int k = 0; k < len; k++) begin
            cu = ($urandom_range(0, 9) == 0) ? 32'h0 : $urandom;
            add_unit(cu, $urandom_range(0, 4) == 0);
        end
    endtask

    task automatic queue_random(int target);
        int start;
        int sel;
        start = queued_total;
        while (queued_total - start < target) begin
            sel = $urandom_range(0, 9);
            if (sel == 0) begin
                queue_noise($urandom_range(1, 8));
            end else if (mode_32) begin
                queue_text32($urandom_range(1, 10));
            end else begin
                queue_text16($urandom_range(1, 10));
            end
        end
    endtask

    task automatic write_mode(logic v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        mode_32      = v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic wait_idle();
        while (units_to_send.size() != 0 || i_valid || pending_bytes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = 1'b0;
        i_valid      = 1'b0;
        i_code_unit  = 32'h0;
        i_ends_text  = 1'b0;
        i_stall      = 1'b0;
        req_accepted = 1'b0;
        mode_32      = 1'b0;
        held_high    = 16'h0000;
        surr_held    = 1'b0;
        discarding   = 1'b0;
        queued_total = 0;
        units_taken  = 0;
        byte_errors  = 0;
        burst_left   = 0;
        gap_left     = 0;
        stall_cyc    = 0;
        stall_mode   = 0;
        hold_left    = 0;
        hold_done    = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_mode(1'b0);
        add_unit(32'h0000_0041, 1'b0);
        add_unit(32'h0000_007F, 1'b0);
        add_unit(32'h0000_0080, 1'b0);
        add_unit(32'h0000_07FF, 1'b0);
        add_unit(32'h0000_0800, 1'b0);
        add_unit(32'h0000_FFFF, 1'b0);
        add_unit(32'h0000_D83D, 1'b0);
        add_unit(32'h0000_DE00, 1'b0);
        add_unit(32'h0000_DC00, 1'b0);
        add_unit(32'h0000_D800, 1'b0);
        add_unit(32'h0000_0042, 1'b0);
        add_unit(32'hABCD_0043, 1'b0);
        add_unit(32'h0000_DBFF, 1'b1);
        add_unit(32'h0000_0000, 1'b0);
        add_unit(32'h0000_1234, 1'b0);
        add_unit(32'h0000_0044, 1'b1);
        add_unit(32'h0000_0000, 1'b1);
        add_unit(32'h0000_D801, 1'b0);
        add_unit(32'h0000_D802, 1'b0);
        wait_idle();

        // The high surrogate still held is dropped by the first 32-bit unit.
        write_mode(1'b1);
        add_unit(32'h0000_0041, 1'b0);
        add_unit(32'h0000_07FF, 1'b0);
        add_unit(32'h0000_FFFF, 1'b0);
        add_unit(32'h0001_0000, 1'b0);
        add_unit(32'h0010_FFFF, 1'b0);
        add_unit(32'h0011_0000, 1'b0);
        add_unit(32'hFFFF_FFFF, 1'b1);
        wait_idle();

        write_mode(1'b0);
        queue_random(60);
        wait_idle();
        write_mode(1'b1);
        queue_random(55);
        wait_idle();
        write_mode(1'b0);
        queue_random(55);
        wait_idle();

        if (pending_bytes.size() != 0) begin
            report_mismatch($sformatf("%0d bytes never arrived", pending_bytes.size()));
        end
        if (byte_errors == 0) begin
            $display("wide_char_to_utf8_encoder test passed");
        end else begin
            $display("wide_char_to_utf8_encoder test failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("wide_char_to_utf8_encoder test failed");
        $finish;
    end

endmodule
